// ----- design/dva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dva_pkg: shared types and constants of the direction vote accumulator
// Operation codes, per-word command carried down the counter chain, and the
// layout of one result word.
// ----------------------------------------------------------------------------
package dva_pkg;

   // widest direction index the chain supports (up to 16 directions)
   localparam int unsigned IDX_MAX_W = 4;

   // operation codes of an input word
   typedef enum logic [1:0] {
      OP_VOTE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_PAUSE = 2'd2
   } op_type;

   // configuration register indexes
   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_PAUSE_TICKS = 2'd1;
   localparam logic [1:0] CSR_FOV = 2'd2;

   // what every counter cell does with a word
   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_VOTE,
      CMD_CLEAR
   } cmd_type;

   // word travelling down the cell chain
   typedef struct packed {
      cmd_type                cmd;
      logic [7:0]             vote_index;
      logic                   clr_latch;
      logic                   paused;
      logic                   hit;
      logic [IDX_MAX_W-1:0]   hit_idx;
   } pkt_type;

   // result word, lowest field last (matches rsp_tdata packing)
   typedef struct packed {
      logic              paused;
      logic signed [8:0] steer_angle;
      logic [7:0]        heading_index;
      logic              obstacle_pending;
   } result_type;

endpackage

// ----- design/dva_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dva_cell: one confidence counter of the chain
// Holds the saturating counter of one direction, applies the word passing by
// and flags a threshold hit to the cells downstream unless it is the center cell.
// ----------------------------------------------------------------------------
module dva_cell
   import dva_pkg::*;
#(
   parameter int unsigned DIRECTIONS = 5,
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] threshold,
   input  logic        in_valid,
   output logic        in_ready,
   input  pkt_type     in_pkt,
   output logic        out_valid,
   input  logic        out_ready,
   output pkt_type     out_pkt
);

   localparam logic [7:0]           MY_INDEX = 8'(CELL_INDEX);
   localparam logic [IDX_MAX_W-1:0] MY_HIT_IDX = IDX_MAX_W'(CELL_INDEX);
   localparam logic                 IS_CENTER = (CELL_INDEX == DIRECTIONS / 2);

   logic        valid_ff;
   logic [15:0] conf_ff;
   logic [15:0] conf_in;
   pkt_type     pkt_ff;
   pkt_type     pkt_in;
   logic        load;

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_pkt = pkt_ff;

   // counter update for the incoming word
   always_comb begin
      conf_in = conf_ff;
      pkt_in = in_pkt;
      case (in_pkt.cmd)
         CMD_CLEAR: begin
            conf_in = '0;
         end
         CMD_VOTE: begin
            if (in_pkt.vote_index == MY_INDEX) begin
               if (conf_ff != 16'hFFFF) begin
                  conf_in = conf_ff + 16'd1;
                  if (conf_in == threshold && !IS_CENTER) begin
                     pkt_in.hit = 1'b1;
                     pkt_in.hit_idx = MY_HIT_IDX;
                  end
               end
            end else if (conf_ff != '0) begin
               conf_in = conf_ff - 16'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         conf_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (load) begin
            conf_ff <= conf_in;
         end
      end
   end

   // word handed on to the neighbor
   always_ff @(posedge clock) begin
      if (load) begin
         pkt_ff <= pkt_in;
      end
   end

endmodule

// ----- design/dva_steer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dva_steer: steer latch and angle computation
// Updates the obstacle latch at the end of the chain, then scales the field
// of view by the direction offset and divides by 2*DIRECTIONS through a
// reciprocal multiply. Ends in the result register.
// ----------------------------------------------------------------------------
module dva_steer
   import dva_pkg::*;
#(
   parameter int unsigned DIRECTIONS = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [8:0] fov,
   input  logic       in_valid,
   output logic       in_ready,
   input  pkt_type    in_pkt,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   localparam int unsigned IDX_W = (DIRECTIONS > 1) ? $clog2(DIRECTIONS) : 1;
   localparam int unsigned NUM_W = 9 + IDX_W;
   localparam int unsigned DIV = 2 * DIRECTIONS;
   localparam int unsigned SHIFT = NUM_W + $clog2(DIV);
   localparam int unsigned M_W = NUM_W + 2;
   localparam int unsigned PROD_W = NUM_W + M_W;
   localparam logic [M_W-1:0] RECIP = M_W'((2 ** SHIFT + DIV - 1) / DIV);
   localparam logic [IDX_W+1:0] N_EXT = (IDX_W + 2)'(DIRECTIONS);

   // stage 1: latch state and scaled magnitude
   logic             s1_valid_ff;
   logic             latched_ff;
   logic             latched_in;
   logic [IDX_W-1:0] chosen_ff;
   logic [IDX_W-1:0] chosen_in;
   logic             s1_paused_ff;
   logic             s1_neg_ff;
   logic [NUM_W-1:0] s1_num_ff;
   logic             s1_ready;
   logic             load1;

   // stage 2: result register
   logic             out_valid_ff;
   result_type       result_ff;
   logic             s2_ready;

   logic [IDX_W+1:0]  twice_p1;
   logic              neg;
   logic [IDX_W+1:0]  coef_wide;
   logic [NUM_W-1:0]  num_in;
   logic [PROD_W-1:0] prod;
   logic [8:0]        quot;

   assign s2_ready = !out_valid_ff || rsp_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;
   assign load1 = in_valid && s1_ready;

   // latch update: begin pause clears, a hit sets and records direction
   always_comb begin
      latched_in = latched_ff;
      chosen_in = chosen_ff;
      if (in_pkt.clr_latch) begin
         latched_in = 1'b0;
      end else if (in_pkt.hit) begin
         latched_in = 1'b1;
         chosen_in = in_pkt.hit_idx[IDX_W-1:0];
      end
   end

   // direction offset 2*idx+1-N as sign and magnitude, times fov
   assign twice_p1 = {1'b0, chosen_in, 1'b1};
   assign neg = twice_p1 < N_EXT;
   assign coef_wide = neg ? (N_EXT - twice_p1) : (twice_p1 - N_EXT);
   assign num_in = NUM_W'(fov) * NUM_W'(coef_wide[IDX_W-1:0]);

   // divide by 2*DIRECTIONS: exact for every numerator below 2**NUM_W
   assign prod = PROD_W'(s1_num_ff) * PROD_W'(RECIP);
   assign quot = prod[SHIFT +: 9];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         latched_ff <= 1'b0;
         chosen_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (load1) begin
            latched_ff <= latched_in;
            chosen_ff <= chosen_in;
         end
         if (s2_ready) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_paused_ff <= in_pkt.paused;
         s1_neg_ff <= neg;
         s1_num_ff <= num_in;
      end
      if (s1_valid_ff && s2_ready) begin
         result_ff.paused <= s1_paused_ff;
         result_ff.steer_angle <= s1_neg_ff ? -$signed(quot) : $signed(quot);
         result_ff.heading_index <= 8'(chosen_ff);
         result_ff.obstacle_pending <= latched_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result = result_ff;

endmodule

// ----- design/direction_vote_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_vote_accumulator: per-direction vote counters with steer latch
// Top level: configuration registers, pause control, counter chain and the
// steer stage.
// ----------------------------------------------------------------------------
// Takes one word per clock unless the output side stalls, and returns one
// result word per input word, in order. A word passes through one counter
// cell per direction and then two steer stages. Throughput is one word a
// cycle when the output side does not stall, set by the counter cell chain,
// which stalls stage by stage and fills any gaps on back-pressure. Pause and
// tick counting happen as a word is taken; the obstacle latch is updated at
// the end of the chain. Configuration writes are accepted every cycle and
// must only happen while no word is in flight.
module direction_vote_accumulator
   import dva_pkg::*;
#(
   parameter int unsigned DIRECTIONS = 5
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] vote_index
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] obstacle_pending, [8:1] heading_index,
                                    // [17:9] steer_angle, [18] paused, rest zero
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] threshold_ff;
   logic [15:0] pause_ticks_ff;
   logic [8:0]  fov_ff;
   logic        pause_ff;
   logic        pause_in;
   logic [15:0] elapsed_ff;
   logic [15:0] elapsed_in;
   pkt_type     head_pkt;
   logic        req_accept;

   logic        chain_valid [DIRECTIONS+1];
   logic        chain_ready [DIRECTIONS+1];
   pkt_type     chain_pkt [DIRECTIONS+1];
   result_type  result;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 16'd10;
         pause_ticks_ff <= 16'd15;
         fov_ff <= 9'd160;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD:   threshold_ff <= csr_data;
            CSR_PAUSE_TICKS: pause_ticks_ff <= csr_data;
            CSR_FOV:         fov_ff <= csr_data[8:0];
            default: begin
            end
         endcase
      end
   end

   // pause control and command for the chain
   always_comb begin
      pause_in = pause_ff;
      elapsed_in = elapsed_ff;
      head_pkt = '0;
      head_pkt.cmd = CMD_NONE;
      head_pkt.vote_index = req_tdata;
      unique case (op_type'(req_tuser))
         OP_VOTE: begin
            if (!pause_ff) begin
               head_pkt.cmd = CMD_VOTE;
            end else if (elapsed_ff >= pause_ticks_ff) begin
               pause_in = 1'b0;
               head_pkt.cmd = CMD_CLEAR;
            end
         end
         OP_TICK: begin
            if (pause_ff && elapsed_ff != 16'hFFFF) begin
               elapsed_in = elapsed_ff + 16'd1;
            end
         end
         OP_PAUSE: begin
            head_pkt.clr_latch = 1'b1;
            pause_in = 1'b1;
            elapsed_in = '0;
         end
         default: begin
         end
      endcase
      head_pkt.paused = pause_in;
   end

   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pause_ff <= 1'b0;
         elapsed_ff <= '0;
      end else if (req_accept) begin
         pause_ff <= pause_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // counter cell chain
   assign chain_valid[0] = req_tvalid;
   assign chain_pkt[0] = head_pkt;
   assign req_tready = chain_ready[0];

   for (genvar k = 0; k < DIRECTIONS; k++) begin : g_cell
      dva_cell #(
         .DIRECTIONS (DIRECTIONS),
         .CELL_INDEX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .threshold (threshold_ff),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_pkt    (chain_pkt[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_pkt   (chain_pkt[k+1])
      );
   end

   // steer latch and angle
   dva_steer #(
      .DIRECTIONS (DIRECTIONS)
   ) u_steer (
      .clock      (clock),
      .reset      (reset),
      .fov        (fov_ff),
      .in_valid   (chain_valid[DIRECTIONS]),
      .in_ready   (chain_ready[DIRECTIONS]),
      .in_pkt     (chain_pkt[DIRECTIONS]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {5'd0, result};

   // checks
   a_heading_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:1] < 8'(DIRECTIONS))
      else $error("heading index out of range");

   a_no_center_steer : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[8:1] != 8'(DIRECTIONS / 2))
      else $error("steer latched on center direction");

   a_pause_starts : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser == OP_PAUSE |=> pause_ff && elapsed_ff == '0)
      else $error("begin pause did not restart the pause");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the direction vote accumulator
// Drives vote, tick, pause and unused-code words through the input stream,
// with random gaps on the sender and a random stall pattern on the receiver.
// Every result word is checked field by field against an in-bench model of
// the counters, the pause timer and the steer latch, over several register
// settings that include the limits of each field.
// ----------------------------------------------------------------------------
module tb_top
   import dva_pkg::*;
();

   localparam int unsigned DIRS       = 5;
   localparam int unsigned LATENCY    = DIRS + 2;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned HOLD_LEN   = 200;
   localparam logic [1:0]  OP_UNUSED  = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] idx;
   } vote_word_type;

   // block ports
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] vote_index
   logic [1:0]  req_tuser  = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [0] obstacle_pending, [8:1] heading_index,
                                  // [17:9] steer_angle, [18] paused
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   direction_vote_accumulator #(.DIRECTIONS(DIRS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model settings and state
   logic [15:0] thr_cfg    = 16'd10;
   logic [15:0] pause_cfg  = 16'd15;
   logic [8:0]  fov_cfg    = 9'd160;
   logic [15:0] conf [DIRS] = '{default: 16'd0};
   logic        pause_on   = 1'b0;
   logic [15:0] ticks_seen = '0;
   logic        latch_on   = 1'b0;
   logic [7:0]  dir_held   = '0;

   vote_word_type vote_words [$];
   result_type    steer_due [$];

   int unsigned words_in     = 0;
   int unsigned results_seen = 0;
   int unsigned steers_seen  = 0;
   int unsigned mismatches   = 0;
   int unsigned settings_run = 0;
   int unsigned gap_left     = 0;
   int unsigned burst_left   = 0;
   int unsigned idle_cycles  = 0;

   // next state and result word for one accepted word
   function automatic result_type steer_step(input logic [1:0] op, input logic [7:0] idx);
      result_type r;
      int         num;
      case (op)
         OP_VOTE: begin
            if (!pause_on) begin
               for (int i = 0; i < DIRS; i++) begin
                  if (i == idx) begin
                     // voted counter rises unless saturated; latch on exact hit
                     if (conf[i] != 16'hFFFF) begin
                        conf[i] = conf[i] + 16'd1;
                        if (conf[i] == thr_cfg && i != DIRS / 2) begin
                           latch_on = 1'b1;
                           dir_held = 8'(i);
                        end
                     end
                  end else if (conf[i] != 16'd0) begin
                     conf[i] = conf[i] - 16'd1;
                  end
               end
            end else if (ticks_seen >= pause_cfg) begin
               // first vote past the pause ends it and is dropped
               pause_on = 1'b0;
               for (int i = 0; i < DIRS; i++) conf[i] = 16'd0;
            end
         end
         OP_TICK: begin
            if (pause_on && ticks_seen != 16'hFFFF) ticks_seen = ticks_seen + 16'd1;
         end
         OP_PAUSE: begin
            latch_on   = 1'b0;
            pause_on   = 1'b1;
            ticks_seen = '0;
         end
         default: ;
      endcase
      num = int'(fov_cfg) * (2 * int'(dir_held) + 1 - int'(DIRS));
      num = num / (2 * int'(DIRS));
      r.obstacle_pending = latch_on;
      r.heading_index    = dir_held;
      r.steer_angle      = num[8:0];
      r.paused           = pause_on;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatches < 20)
         $display("tb_top: mismatch on %s at result %0d: expected %0h, got %0h",
                  what, results_seen, want, got);
      mismatches++;
   endtask

   // sender: bursts of words with random gaps, holds a word until taken
   always @(posedge clock) begin : drive_p
      vote_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            steer_due.push_back(steer_step(req_tuser, req_tdata));
            words_in++;
         end
         if (req_tvalid && !req_tready) begin
            // word still offered
         end else if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (vote_words.size() != 0) begin
            w = vote_words.pop_front();
            req_tuser  <= w.op;
            req_tdata  <= w.idx;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(5, 20);
               else if ($urandom_range(0, 3) == 0) gap_left = 0;
               else gap_left = $urandom_range(1, 3);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern that changes mode, plus one long hold-off
   always @(posedge clock) begin : accept_p
      int unsigned taken;
      int unsigned hold_left;
      int unsigned mode;
      int unsigned mode_left;
      int unsigned phase_cnt;
      bit          hold_done;
      if (rsp_tvalid && rsp_tready) taken++;
      phase_cnt++;
      if (!hold_done && taken >= 300 && req_tvalid) begin
         hold_left = HOLD_LEN;
         hold_done = 1'b1;
      end
      if (mode_left == 0) begin
         mode      = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 80);
      end else begin
         mode_left--;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= phase_cnt[2];
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin : check_p
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (steer_due.size() == 0) begin
            report_mismatch("word with nothing expected", 32'd0, 32'(rsp_tdata));
         end else begin
            want = steer_due.pop_front();
            if (want.obstacle_pending) steers_seen++;
            if (rsp_tdata[0] !== want.obstacle_pending)
               report_mismatch("obstacle_pending", 32'(want.obstacle_pending), 32'(rsp_tdata[0]));
            if (rsp_tdata[8:1] !== want.heading_index)
               report_mismatch("heading_index", 32'(want.heading_index), 32'(rsp_tdata[8:1]));
            if (rsp_tdata[17:9] !== want.steer_angle)
               report_mismatch("steer_angle", 32'($unsigned(want.steer_angle)),
                               32'(rsp_tdata[17:9]));
            if (rsp_tdata[18] !== want.paused)
               report_mismatch("paused", 32'(want.paused), 32'(rsp_tdata[18]));
            if (rsp_tdata[23:19] !== 5'd0)
               report_mismatch("padding", 32'd0, 32'(rsp_tdata[23:19]));
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic add_word(input logic [1:0] op, input logic [7:0] idx);
      vote_words.push_back('{op: op, idx: idx});
   endtask

   // wait until every word is sent and answered, then let the chain settle;
   // sampled mid-cycle so the sender's updates at the edge are visible
   task automatic wait_idle();
      do @(negedge clock);
      while (vote_words.size() != 0 || req_tvalid || steer_due.size() != 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_put(input logic [1:0] index, input logic [15:0] value);
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (index)
         CSR_THRESHOLD:   thr_cfg   = value;
         CSR_PAUSE_TICKS: pause_cfg = value;
         CSR_FOV:         fov_cfg   = value[8:0];
         default: ;
      endcase
   endtask

   // writes all three registers back to back, valid held high throughout
   task automatic load_settings(input logic [15:0] thr, input logic [15:0] ticks,
                                input logic [8:0] fov);
      csr_valid <= 1'b1;
      csr_put(CSR_THRESHOLD, thr);
      csr_put(CSR_PAUSE_TICKS, ticks);
      csr_put(CSR_FOV, {7'd0, fov});
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   // runs of votes leaning to one direction, with ticks, pauses and noise
   task automatic random_run(input int count);
      int         fav;
      int         run_left;
      int         r;
      logic [7:0] idx;
      fav      = 0;
      run_left = 0;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            fav      = $urandom_range(0, DIRS - 1);
            run_left = $urandom_range(4, 30);
         end
         run_left--;
         r = $urandom_range(0, 99);
         if (r < 68) begin
            case ($urandom_range(0, 11))
               0, 1:    idx = 8'($urandom_range(0, DIRS - 1));
               2:       idx = 8'($urandom_range(0, 255));
               default: idx = 8'(fav);
            endcase
            add_word(OP_VOTE, idx);
         end else if (r < 88) begin
            add_word(OP_TICK, 8'($urandom_range(0, 255)));
         end else if (r < 96) begin
            add_word(OP_PAUSE, 8'($urandom_range(0, 255)));
         end else begin
            add_word(OP_UNUSED, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: latches left and right, center, out of range, unused code,
      // stray tick, pause timing and pause restart
      load_settings(16'd2, 16'd1, 9'd360);
      add_word(OP_VOTE, 8'd0);
      add_word(OP_VOTE, 8'd0);
      add_word(OP_VOTE, 8'd2);
      add_word(OP_VOTE, 8'd2);
      add_word(OP_VOTE, 8'd2);
      add_word(OP_VOTE, 8'hFF);
      add_word(OP_VOTE, 8'(DIRS));
      add_word(OP_UNUSED, 8'hAA);
      add_word(OP_TICK, 8'h55);
      add_word(OP_VOTE, 8'd4);
      add_word(OP_VOTE, 8'd4);
      add_word(OP_PAUSE, 8'd0);
      add_word(OP_VOTE, 8'd4);
      add_word(OP_TICK, 8'd0);
      add_word(OP_TICK, 8'd0);
      add_word(OP_VOTE, 8'd1);
      add_word(OP_PAUSE, 8'd0);
      add_word(OP_PAUSE, 8'hFF);
      add_word(OP_TICK, 8'd0);
      add_word(OP_VOTE, 8'd3);
      add_word(OP_VOTE, 8'd1);
      add_word(OP_VOTE, 8'd1);
      add_word(OP_VOTE, 8'd3);
      add_word(OP_VOTE, 8'd3);
      wait_idle();

      // random content under a spread of settings
      load_settings(16'd1, 16'd0, 9'd0);
      random_run(250);
      wait_idle();
      load_settings(16'd0, 16'd3, 9'd1);
      random_run(230);
      wait_idle();
      load_settings(16'd3, 16'd2, 9'd360);
      random_run(250);
      wait_idle();
      load_settings(16'($urandom_range(1, 6)), 16'($urandom_range(0, 6)),
                    9'($urandom_range(0, 360)));
      random_run(250);
      wait_idle();

      // top of every register range: threshold and pause length out of reach
      load_settings(16'hFFFF, 16'hFFFF, 9'h1FF);
      for (int n = 0; n < 10; n++) add_word(OP_VOTE, 8'd0);
      add_word(OP_VOTE, 8'd1);
      add_word(OP_VOTE, 8'd0);
      add_word(OP_PAUSE, 8'd0);
      for (int n = 0; n < 6; n++) add_word(OP_TICK, 8'd0);
      add_word(OP_VOTE, 8'd4);
      add_word(OP_VOTE, 8'd4);
      random_run(40);
      wait_idle();

      load_settings(16'd4, 16'd15, 9'd160);
      random_run(250);
      wait_idle();

      $display("tb_top: %0d words sent, %0d results checked, %0d with a steer latched",
               words_in, results_seen, steers_seen);
      $display("tb_top: %0d register settings, %0d mismatches", settings_run, mismatches);
      if (mismatches == 0 && steer_due.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
